// ===== hw/rtl/adpcm4_pkg.sv =====
// Shared types, constants and the step table for the four-bit ADPCM codec.
package adpcm4_pkg;

    // Field and state widths.
    localparam int X_W     = 16;
    localparam int CODE_W  = 4;
    localparam int LVL_W   = 20;
    localparam int STEP_W  = 10;
    localparam int MAG_W   = 3;
    localparam int DELTA_W = 14;
    localparam int QBITS   = 4;
    localparam int QCNT_W  = 2;

    // Level and output limits.
    localparam int LVL_MAX = 524287;
    localparam int LVL_MIN = -524288;
    localparam int PCM_MAX = 32767;
    localparam int PCM_MIN = -32768;

    // Reset value of both step registers.
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd32;

    // Configuration direction codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LEAK = 7'b0000010,
        ST_DIFF = 7'b0000100,
        ST_BIAS = 7'b0001000,
        ST_QUO  = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_ADD  = 7'b1000000
    } state_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic start;
        logic decode;
        logic quo_last;
        logic out_free;
    } seq_in_t;

    // Step size for each magnitude index.
    function automatic logic [STEP_W-1:0] step_of(input logic [MAG_W-1:0] mag);
        logic [STEP_W-1:0] s;
        unique case (mag)
            3'd0:    s = 10'd32;
            3'd1:    s = 10'd48;
            3'd2:    s = 10'd71;
            3'd3:    s = 10'd105;
            3'd4:    s = 10'd156;
            3'd5:    s = 10'd232;
            3'd6:    s = 10'd345;
            default: s = 10'd512;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/adpcm4_alu.sv =====
// Shared add/subtract unit used by every step of the codec except the multiply.
module adpcm4_alu #(
    parameter int AW = 28
) (
    input  logic signed [AW-1:0] a,
    input  logic signed [AW-1:0] b,
    input  logic                 sub,
    output logic signed [AW-1:0] y,
    output logic                 neg
);

    // One adder, with the second operand optionally negated.
    always_comb
    begin
        if (sub)
        begin
            y = a - b;
        end
        else
        begin
            y = a + b;
        end
        neg = y[AW-1];
    end

endmodule

// ===== hw/rtl/adpcm4_seq.sv =====
// One-item sequencer: leak, diff, bias, quotient (encode only), mul, update.
module adpcm4_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  adpcm4_pkg::seq_in_t ctl,
    output adpcm4_pkg::state_t  state
);

    adpcm4_pkg::state_t state_reg;
    adpcm4_pkg::state_t state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            adpcm4_pkg::ST_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = adpcm4_pkg::ST_LEAK;
                end
            end
            adpcm4_pkg::ST_LEAK:
            begin
                state_next = ctl.decode ? adpcm4_pkg::ST_MUL : adpcm4_pkg::ST_DIFF;
            end
            adpcm4_pkg::ST_DIFF: state_next = adpcm4_pkg::ST_BIAS;
            adpcm4_pkg::ST_BIAS: state_next = adpcm4_pkg::ST_QUO;
            adpcm4_pkg::ST_QUO:
            begin
                if (ctl.quo_last)
                begin
                    state_next = adpcm4_pkg::ST_MUL;
                end
            end
            adpcm4_pkg::ST_MUL:  state_next = adpcm4_pkg::ST_ADD;
            adpcm4_pkg::ST_ADD:
            begin
                if (ctl.out_free)
                begin
                    state_next = adpcm4_pkg::ST_IDLE;
                end
            end
            default: state_next = adpcm4_pkg::ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= adpcm4_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ===== hw/rtl/adpcm_4bit_codec_top.sv =====
// Top level of the four-bit ADPCM codec: datapath registers, operand selection and ports.
//
//   Channel      Direction  Contents (lowest bit first)
//   s_axis       in         tdata[15:0] sample_or_code
//   m_axis       out        tdata[3:0] code_out, [19:4] pcm_out, [23:20] zero
//   cfg_wr_*     in         cfg_wr_data: direction (0 encode, 1 decode)
//
// Encode runs leak, difference, bias, quotient, multiply and update; decode runs leak,
// multiply and update. Both begin in the idle state, where the next transaction is
// accepted. Each add or subtract is one pass through the shared adder; the encoder
// quotient takes one bit per cycle. Reset clears the level to zero and both step
// registers to 32; no clearing pass. A finished result waits in the output register;
// the update step stalls only while that register is still full and not being taken.
module adpcm_4bit_codec_top #(
    parameter int LEAK_SHIFT = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_or_code
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] code_out, [19:4] pcm_out, [23:20] zero
    // Configuration.
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    localparam int LVL_W   = adpcm4_pkg::LVL_W;
    localparam int STEP_W  = adpcm4_pkg::STEP_W;
    localparam int X_W     = adpcm4_pkg::X_W;
    localparam int CODE_W  = adpcm4_pkg::CODE_W;
    localparam int DELTA_W = adpcm4_pkg::DELTA_W;
    localparam int MAG_W   = adpcm4_pkg::MAG_W;
    localparam int QBITS   = adpcm4_pkg::QBITS;
    localparam int QCNT_W  = adpcm4_pkg::QCNT_W;
    localparam int AW      = LVL_W + LEAK_SHIFT + 2;

    localparam logic signed [AW-1:0] LVL_MAX_A = AW'(adpcm4_pkg::LVL_MAX);
    localparam logic signed [AW-1:0] LVL_MIN_A = AW'(adpcm4_pkg::LVL_MIN);
    localparam logic signed [LVL_W-1:0] PCM_MAX_L = LVL_W'(adpcm4_pkg::PCM_MAX);
    localparam logic signed [LVL_W-1:0] PCM_MIN_L = LVL_W'(adpcm4_pkg::PCM_MIN);
    localparam logic [AW-1:0] LEAK_ROUND = AW'(1) << (LEAK_SHIFT - 1);

    // Control state.
    adpcm4_pkg::state_t        state;
    adpcm4_pkg::seq_in_t       seq_ctl;
    logic                      dir_reg;
    logic signed [LVL_W-1:0]   level_reg,  level_next;
    logic [STEP_W-1:0]         recent_reg, recent_next;
    logic [STEP_W-1:0]         older_reg,  older_next;
    logic                      out_valid_reg, out_valid_next;
    logic [QCNT_W-1:0]         cnt_reg,    cnt_next;

    // Working and result registers.
    logic signed [X_W-1:0]     x_reg,      x_next;
    logic signed [LVL_W-1:0]   leak_reg,   leak_next;
    logic [STEP_W-1:0]         step_reg,   step_next;
    logic signed [AW-1:0]      acc_reg,    acc_next;
    logic                      neg_reg,    neg_next;
    logic [QBITS-1:0]          q_reg,      q_next;
    logic [CODE_W-1:0]         code_reg,   code_next;
    logic [DELTA_W-1:0]        delta_reg,  delta_next;
    logic [CODE_W-1:0]         code_out_reg, code_out_next;
    logic signed [X_W-1:0]     pcm_out_reg,  pcm_out_next;

    // Shared adder operands.
    logic signed [AW-1:0]      alu_a, alu_b, alu_y;
    logic                      alu_sub, alu_neg;

    logic                      in_fire, out_free, add_fire;
    logic [STEP_W+1:0]         step_sum;
    logic signed [AW-1:0]      lvl_ext;
    logic [AW-1:0]             divisor;
    logic [QBITS-1:0]          q_final;
    logic [MAG_W-1:0]          q_mag;
    logic signed [LVL_W-1:0]   level_sat;
    logic [DELTA_W-1:0]        delta_prod;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign add_fire      = (state == adpcm4_pkg::ST_ADD) && out_free;
    assign s_axis_tready = (state == adpcm4_pkg::ST_IDLE);

    assign seq_ctl.start    = in_fire;
    assign seq_ctl.decode   = (dir_reg == adpcm4_pkg::DIR_DECODE);
    assign seq_ctl.quo_last = (cnt_reg == '0);
    assign seq_ctl.out_free = out_free;

    adpcm4_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (seq_ctl),
        .state (state)
    );

    adpcm4_alu #(
        .AW (AW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y),
        .neg (alu_neg)
    );

    // Quantizer step: rounded weighted mean of the recent step (weight one) and the older step (weight three).
    assign step_sum = {2'b00, recent_reg} + {1'b0, older_reg, 1'b0} + {2'b00, older_reg}
                    + (STEP_W+2)'(2);
    assign lvl_ext  = AW'(level_reg);
    assign divisor  = {{(AW-STEP_W-1){1'b0}}, step_reg, 1'b0} << cnt_reg;

    // Final quotient bit, then clamp of the magnitude to seven.
    always_comb
    begin
        q_final = q_reg;
        if (!alu_neg)
        begin
            q_final[cnt_reg] = 1'b1;
        end
        q_mag = q_final[QBITS-1] ? '1 : q_final[MAG_W-1:0];
    end

    // Delta for the applied code: step times (2m+1).
    assign delta_prod = step_reg * {code_reg[MAG_W-1:0], 1'b1};

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state)
            adpcm4_pkg::ST_LEAK:
            begin
                // L*(2^S - 1) + 2^(S-1); low bits of the shifted level are zero.
                alu_a   = (lvl_ext <<< LEAK_SHIFT) | LEAK_ROUND;
                alu_b   = lvl_ext;
                alu_sub = 1'b1;
            end
            adpcm4_pkg::ST_DIFF:
            begin
                alu_a   = AW'(x_reg);
                alu_b   = AW'(leak_reg);
                alu_sub = 1'b1;
            end
            adpcm4_pkg::ST_BIAS:
            begin
                // |d| + step + 1, folding the absolute value into the operation.
                if (neg_reg)
                begin
                    alu_a   = AW'({1'b0, step_reg} + (STEP_W+1)'(1));
                    alu_b   = acc_reg;
                    alu_sub = 1'b1;
                end
                else
                begin
                    alu_a   = acc_reg;
                    alu_b   = AW'({1'b0, step_reg} + (STEP_W+1)'(1));
                end
            end
            adpcm4_pkg::ST_QUO:
            begin
                alu_a   = acc_reg;
                alu_b   = divisor;
                alu_sub = 1'b1;
            end
            adpcm4_pkg::ST_ADD:
            begin
                alu_a   = AW'(leak_reg);
                alu_b   = AW'({1'b0, delta_reg});
                alu_sub = code_reg[CODE_W-1];
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Level saturation after the update.
    always_comb
    begin
        if (alu_y > LVL_MAX_A)
        begin
            level_sat = LVL_W'(adpcm4_pkg::LVL_MAX);
        end
        else if (alu_y < LVL_MIN_A)
        begin
            level_sat = LVL_W'(adpcm4_pkg::LVL_MIN);
        end
        else
        begin
            level_sat = alu_y[LVL_W-1:0];
        end
    end

    // Next values of all registers.
    always_comb
    begin
        level_next     = level_reg;
        recent_next    = recent_reg;
        older_next     = older_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        leak_next      = leak_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        code_next      = code_reg;
        delta_next     = delta_reg;
        code_out_next  = code_out_reg;
        pcm_out_next   = pcm_out_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state)
            adpcm4_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next    = s_axis_tdata;
                    code_next = s_axis_tdata[CODE_W-1:0];
                end
            end
            adpcm4_pkg::ST_LEAK:
            begin
                leak_next = alu_y[LVL_W+LEAK_SHIFT-1:LEAK_SHIFT];
                step_next = step_sum[STEP_W+1:2];
            end
            adpcm4_pkg::ST_DIFF:
            begin
                acc_next = alu_y;
                neg_next = alu_neg;
            end
            adpcm4_pkg::ST_BIAS:
            begin
                acc_next = alu_y;
                cnt_next = '1;
                q_next   = '0;
            end
            adpcm4_pkg::ST_QUO:
            begin
                // Restoring division, one quotient bit per cycle.
                if (!alu_neg)
                begin
                    acc_next = alu_y;
                end
                q_next   = q_final;
                cnt_next = cnt_reg - QCNT_W'(1);
                if (cnt_reg == '0)
                begin
                    code_next = {neg_reg, q_mag};
                end
            end
            adpcm4_pkg::ST_MUL:
            begin
                delta_next = delta_prod;
            end
            adpcm4_pkg::ST_ADD:
            begin
                if (add_fire)
                begin
                    level_next     = level_sat;
                    older_next     = recent_reg;
                    recent_next    = adpcm4_pkg::step_of(code_reg[MAG_W-1:0]);
                    out_valid_next = 1'b1;
                    code_out_next  = code_reg;
                    if (level_sat > PCM_MAX_L)
                    begin
                        pcm_out_next = X_W'(adpcm4_pkg::PCM_MAX);
                    end
                    else if (level_sat < PCM_MIN_L)
                    begin
                        pcm_out_next = X_W'(adpcm4_pkg::PCM_MIN);
                    end
                    else
                    begin
                        pcm_out_next = level_sat[X_W-1:0];
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= adpcm4_pkg::DIR_ENCODE;
            level_reg     <= '0;
            recent_reg    <= adpcm4_pkg::STEP_RESET;
            older_reg     <= adpcm4_pkg::STEP_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dir_reg <= cfg_wr_data;
            end
            level_reg     <= level_next;
            recent_reg    <= recent_next;
            older_reg     <= older_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        leak_reg     <= leak_next;
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        q_reg        <= q_next;
        code_reg     <= code_next;
        delta_reg    <= delta_next;
        code_out_reg <= code_out_next;
        pcm_out_reg  <= pcm_out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, pcm_out_reg, code_out_reg};

`ifndef SYNTH
    // An accepted transaction always starts with the leak step.
    a_start_leak: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state == adpcm4_pkg::ST_LEAK))
        else $error("accepted transaction did not start with the leak step");

    // A new result appears only out of the update step.
    a_result_from_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state == adpcm4_pkg::ST_ADD))
        else $error("result appeared outside the update step");

    // The quotient never divides by a zero step.
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state == adpcm4_pkg::ST_QUO) |-> (step_reg != '0))
        else $error("zero step during quotient");

    // The update step never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(pcm_out_reg))
        else $error("waiting result was overwritten");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the four-bit ADPCM codec top level.
`timescale 1ns / 100ps

module tb;

    localparam int LEAK_SHIFT  = 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;

    // One expected output transaction.
    typedef struct {
        logic [adpcm4_pkg::CODE_W-1:0] code;
        logic [adpcm4_pkg::X_W-1:0]    pcm;
    } codec_result_t;

    // Tracks the codec state and holds the expected output transactions in order.
    class codec_scoreboard;
        logic                                dir;
        logic signed [adpcm4_pkg::LVL_W-1:0] level;
        logic [adpcm4_pkg::STEP_W-1:0]       recent;
        logic [adpcm4_pkg::STEP_W-1:0]       older;
        codec_result_t                       expected_q[$];
        int                                  errors;
        int                                  results_seen;
        longint                              step_sizes[8];

        function new();
            dir          = adpcm4_pkg::DIR_ENCODE;
            level        = '0;
            recent       = 10'd32;
            older        = 10'd32;
            errors       = 0;
            results_seen = 0;
            step_sizes   = '{32, 48, 71, 105, 156, 232, 345, 512};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Predict the result of one accepted input transaction and advance the state.
        function void note_sample(logic [adpcm4_pkg::X_W-1:0] din);
            longint        step;
            longint        leaked;
            longint        diff;
            longint        mag;
            longint        divisor;
            longint        quo;
            longint        delta;
            longint        next_lvl;
            longint        pcm;
            int            m;
            logic [3:0]    code;
            codec_result_t res;

            step   = (longint'(recent) + 3 * longint'(older) + 2) >> 2;
            // Leak toward zero; the arithmetic shift rounds toward minus infinity.
            leaked = (longint'(level) * ((1 << LEAK_SHIFT) - 1) + (1 << (LEAK_SHIFT - 1)))
                     >>> LEAK_SHIFT;

            if (dir == adpcm4_pkg::DIR_DECODE)
            begin
                code = din[3:0];
            end
            else
            begin
                diff    = longint'($signed(din)) - leaked;
                mag     = (diff < 0) ? -diff : diff;
                divisor = 2 * step;
                if (divisor == 0)
                    divisor = 1;
                quo = (mag + step + 1) / divisor;
                if (quo > 7)
                    quo = 7;
                code = {(diff < 0), quo[2:0]};
            end

            // Apply the code as the decoder does and saturate the level.
            m        = int'(code[2:0]);
            delta    = step * (2 * m + 1);
            next_lvl = code[3] ? leaked - delta : leaked + delta;
            if (next_lvl > adpcm4_pkg::LVL_MAX)
                next_lvl = adpcm4_pkg::LVL_MAX;
            if (next_lvl < adpcm4_pkg::LVL_MIN)
                next_lvl = adpcm4_pkg::LVL_MIN;
            level  = next_lvl[adpcm4_pkg::LVL_W-1:0];
            older  = recent;
            recent = step_sizes[m][adpcm4_pkg::STEP_W-1:0];

            pcm = next_lvl;
            if (pcm > adpcm4_pkg::PCM_MAX)
                pcm = adpcm4_pkg::PCM_MAX;
            if (pcm < adpcm4_pkg::PCM_MIN)
                pcm = adpcm4_pkg::PCM_MIN;
            res.code = code;
            res.pcm  = pcm[adpcm4_pkg::X_W-1:0];
            expected_q.push_back(res);
        endfunction

        // Compare one accepted output transaction with the oldest expectation.
        function void check_result(logic [23:0] dout);
            codec_result_t res;

            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("output transaction with no expectation pending: tdata=%h", dout);
                errors++;
                return;
            end
            res = expected_q.pop_front();
            if (dout[3:0] !== res.code)
            begin
                $error("code_out expected %0d got %0d", res.code, dout[3:0]);
                errors++;
            end
            if (dout[19:4] !== res.pcm)
            begin
                $error("pcm_out expected %0d got %0d", $signed(res.pcm), $signed(dout[19:4]));
                errors++;
            end
            if (dout[23:20] !== 4'd0)
            begin
                $error("tdata padding expected 0 got %0d", dout[23:20]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic        cfg_wr_data;

    codec_scoreboard sb = new();
    int              cycle_count = 0;
    bit              no_idle = 1'b0;
    bit              hold_done = 1'b0;

    adpcm_4bit_codec_top #(
        .LEAK_SHIFT (LEAK_SHIFT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Watch both streams and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: random back-pressure plus one long hold-off that stalls the update step.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.results_seen >= 150)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = rand_gap();
            end
        end
    end

    // Offer one input transaction after an optional gap and wait until it is taken.
    task automatic send_item(input logic [15:0] data);
        int gap;
        gap = rand_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop offering input and wait until every expected transaction has come out.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write the direction register while the codec is idle.
    task automatic set_direction(input logic dir);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        sb.dir = dir;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stimulus.
    initial
    begin
        int          cur;
        int          r;
        int          run_left;
        logic [3:0]  run_code;
        logic [15:0] data;
        logic [15:0] directed [10];

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        directed      = '{16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                          16'h8000, 16'h8000, 16'h0001, 16'hFFFF};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed encode: zero difference, full-scale samples, small values.
        set_direction(adpcm4_pkg::DIR_ENCODE);
        foreach (directed[i])
        begin
            send_item(directed[i]);
        end

        // Directed decode: every code, with the ignored upper bits set for odd codes and clear for even ones.
        set_direction(adpcm4_pkg::DIR_DECODE);
        for (int c = 0; c < 16; c++)
        begin
            send_item((c % 2) ? {12'hFFF, 4'(c)} : {12'h000, 4'(c)});
        end

        // Random phases alternating between encode and decode.
        cur      = 0;
        run_left = 0;
        run_code = 4'd0;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_direction((ph % 2) ? adpcm4_pkg::DIR_ENCODE : adpcm4_pkg::DIR_DECODE);
            no_idle = (ph % 4 == 3);
            for (int n = 0; n < 60; n++)
            begin
                if (ph % 2)
                begin
                    // Encode: mostly a random walk, some full-range and full-scale samples.
                    r = $urandom_range(0, 99);
                    if (r < 50)
                    begin
                        cur = cur + int'($urandom_range(0, 4096)) - 2048;
                        if (cur > adpcm4_pkg::PCM_MAX)
                            cur = adpcm4_pkg::PCM_MAX;
                        if (cur < adpcm4_pkg::PCM_MIN)
                            cur = adpcm4_pkg::PCM_MIN;
                    end
                    else if (r < 75)
                    begin
                        cur = int'($signed(16'($urandom())));
                    end
                    else if (r < 90)
                    begin
                        case ($urandom_range(0, 3))
                            0:       cur = adpcm4_pkg::PCM_MAX;
                            1:       cur = adpcm4_pkg::PCM_MIN;
                            2:       cur = 0;
                            default: cur = -1;
                        endcase
                    end
                    data = cur[15:0];
                end
                else
                begin
                    // Decode: runs of one code push the level to the clamp limits.
                    if (run_left == 0)
                    begin
                        run_left = $urandom_range(1, 20);
                        run_code = 4'($urandom());
                    end
                    run_left--;
                    data = {12'($urandom()), run_code};
                end
                send_item(data);
            end
        end

        // Let the pipeline empty and the last result settle.
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/adpcm4_pkg.sv
hw/rtl/adpcm4_alu.sv
hw/rtl/adpcm4_seq.sv
hw/rtl/adpcm_4bit_codec_top.sv
verif/tb.sv
